>>> design/four_level_page_table_walk_defines.svh
// assertion macros used by the page table walk sequencer
// expects clk and arst_n in the scope of each use
`ifndef FOUR_LEVEL_PAGE_TABLE_WALK_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALK_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PTW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptw assertion failed");

// next-cycle implication
`define PTW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptw assertion failed");

`else

`define PTW_ASSERT_IMP(lbl, ante, cons)
`define PTW_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> design/ptw_pkg.sv
// types and constants of the four level page table walker
// no dependencies
package ptw_pkg;

	// fixed geometry of one table and of an entry
	localparam int TABLE_ENTRIES = 512;
	localparam int PA_W          = 52;
	localparam int VA_W          = 48;
	localparam int IDX_W         = 12;
	localparam int ENTRY_W       = 64;
	localparam int PRESENT_BIT   = 0;
	localparam int PS_BIT        = 7;

	// input kinds
	localparam logic ACT_WRITE     = 1'b0;
	localparam logic ACT_TRANSLATE = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_NOT_PRESENT = 2'd1;
	localparam logic [1:0] STAT_OUTSIDE     = 2'd2;
	localparam logic [1:0] STAT_MISALIGNED  = 2'd3;

	// register index of the root table address
	localparam logic REG_ROOT = 1'b0;

	// level codes, counting down from the top table
	localparam logic [1:0] LVL_4 = 2'd3;
	localparam logic [1:0] LVL_3 = 2'd2;
	localparam logic [1:0] LVL_2 = 2'd1;
	localparam logic [1:0] LVL_1 = 2'd0;

	typedef struct packed {
		logic               action;
		logic [IDX_W-1:0]   word_index;
		logic [ENTRY_W-1:0] word_data;
		logic [VA_W-1:0]    virt_addr;
	} ptw_item_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [PA_W-1:0] phys_result;
	} ptw_res_t;

endpackage

>>> design/ptw_store.sv
// local store of page table words, one write and one registered read port
// depends on ptw_pkg
module ptw_store
	import ptw_pkg::*;
#(
	parameter int STORE_WORDS = 4096,
	parameter int AW          = 12
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [ENTRY_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [ENTRY_W-1:0] rd_data
);

	logic [ENTRY_W-1:0] mem_q [STORE_WORDS];
	logic [ENTRY_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/ptw_cfg.sv
// apb register block holding the root table address
// depends on ptw_pkg
module ptw_cfg
	import ptw_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [63:0]     pwdata,
	output logic [63:0]     prdata,
	output logic            pready,
	output logic [PA_W-1:0] root_addr
);

	logic [PA_W-1:0] root_q;
	logic            wr_hit;

	// register decode on the 8-byte slot
	assign wr_hit = psel && penable && pwrite && (paddr[3] == REG_ROOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (wr_hit) begin
			root_q <= pwdata[PA_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (paddr[3] == REG_ROOT) begin
			prdata = {{(64-PA_W){1'b0}}, root_q};
		end
	end

	assign pready    = 1'b1;
	assign root_addr = root_q;

endmodule

>>> design/ptw_seq.sv
// walk sequencer: one level per pass through a shared lookup/evaluate unit
// depends on ptw_pkg and the assertion macro header
`include "four_level_page_table_walk_defines.svh"

module ptw_seq
	import ptw_pkg::*;
#(
	parameter int STORE_WORDS = 4096,
	parameter int AW          = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ptw_item_t          item,
	input  logic [PA_W-1:0]    root_addr,
	output logic               res_valid,
	input  logic               res_ready,
	output ptw_res_t           res,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [ENTRY_W-1:0] wr_data,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  logic [ENTRY_W-1:0] rd_data
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOOKUP = 2'd1;
	localparam logic [1:0] ST_EVAL   = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	localparam logic [49:0] STORE_END = 50'(STORE_WORDS);
	localparam logic [49:0] TBL_SPAN  = 50'(TABLE_ENTRIES);

	logic [1:0]      state_q;
	logic [1:0]      level_q;
	logic [PA_W-1:0] cur_q;
	logic [VA_W-1:0] va_q;
	ptw_res_t        res_q;

	logic            accept;
	logic [31:0]     widx32;
	logic [49:0]     tbl_end;
	logic            outside;
	logic [8:0]      idx;
	logic [48:0]     rd_full;
	logic            present;
	logic            leaf;
	logic            descend;
	logic [PA_W-1:0] phys;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// store write straight from the accepted item
	assign widx32  = {{(32-IDX_W){1'b0}}, item.word_index};
	assign wr_en   = accept && (item.action == ACT_WRITE) && (widx32 < 32'(STORE_WORDS));
	assign wr_addr = widx32[AW-1:0];
	assign wr_data = item.word_data;

	// table bounds check for the current level
	assign tbl_end = {1'b0, cur_q[PA_W-1:3]} + TBL_SPAN;
	assign outside = tbl_end > STORE_END;

	// entry index from the virtual address
	always_comb begin
		case (level_q)
			LVL_4:   idx = va_q[47:39];
			LVL_3:   idx = va_q[38:30];
			LVL_2:   idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
	end

	assign rd_full = {cur_q[PA_W-1:12], idx};
	assign rd_addr = rd_full[AW-1:0];
	assign rd_en   = (state_q == ST_LOOKUP) && !outside;

	// entry evaluation
	assign present = rd_data[PRESENT_BIT];
	assign leaf    = (level_q == LVL_1)
		|| (((level_q == LVL_2) || (level_q == LVL_3)) && rd_data[PS_BIT]);
	assign descend = (state_q == ST_EVAL) && present && !leaf;

	// leaf frame joined with the page offset
	always_comb begin
		case (level_q)
			LVL_3:   phys = {rd_data[51:30], va_q[29:0]};
			LVL_2:   phys = {rd_data[51:21], va_q[20:0]};
			default: phys = {rd_data[51:12], va_q[11:0]};
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.action == ACT_WRITE || root_addr[11:0] != 12'd0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_LOOKUP;
						end
					end
				end
				ST_LOOKUP: begin
					state_q <= outside ? ST_DONE : ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= descend ? ST_LOOKUP : ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cur_q   <= root_addr;
					va_q    <= item.virt_addr;
					level_q <= LVL_4;
					if (item.action == ACT_WRITE) begin
						res_q <= '{status: STAT_OK, phys_result: '0};
					end else begin
						res_q <= '{status: STAT_MISALIGNED, phys_result: '0};
					end
				end
			end
			ST_LOOKUP: begin
				if (outside) begin
					res_q <= '{status: STAT_OUTSIDE, phys_result: '0};
				end
			end
			ST_EVAL: begin
				if (!present) begin
					res_q <= '{status: STAT_NOT_PRESENT, phys_result: '0};
				end else if (leaf) begin
					res_q <= '{status: STAT_OK, phys_result: phys};
				end else begin
					cur_q   <= {rd_data[51:12], 12'd0};
					level_q <= level_q - 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// a lookup inside the store is always followed by an evaluation
	`PTW_ASSERT_NXT(a_lookup_to_eval, (state_q == ST_LOOKUP) && !outside, state_q == ST_EVAL)
	// each descent moves exactly one level down
	`PTW_ASSERT_NXT(a_level_down, descend, level_q == $past(level_q) - 2'd1)
	// a faulting result never carries an address
	`PTW_ASSERT_IMP(a_fault_zero, res_valid && (res_q.status != STAT_OK),
		res_q.phys_result == '0)
	// a descent never happens from the last level
	`PTW_ASSERT_IMP(a_no_descent_l1, descend, level_q != LVL_1)

endmodule

>>> design/four_level_page_table_walk.sv
// Four level page table walker with a private store of 64-bit table words.
// Input stream s_*: s_tuser is the action (0 store write, 1 translate);
// s_tdata carries word_index, word_data and virt_addr. Every input transaction
// returns one result transaction on m_*: status and phys_result in m_tdata.
// The APB port holds root_table_addr at byte address 0 (64-bit data).
// A store write goes from acceptance to the done state and then the output
// register. A translation walks up to 4 levels, each a lookup state (bounds
// check and store read) then an evaluation state, and then goes through the
// done state to the output register. A table outside the store ends the walk
// at its bounds check, with no evaluation. A misaligned root goes straight
// to the done state.
// The store's single registered read port parts each level into lookup and
// evaluation. One item is in the walker at a time and s_tready is low meanwhile.
// A finished result waits in the output register while the walker takes the
// next item; if m_tready stays low the walker holds its next result.
// Reset clears the sequencer, the output valid and the root register; the
// store content is undefined until written.
// depends on ptw_pkg, ptw_cfg, ptw_store, ptw_seq
module four_level_page_table_walk
	import ptw_pkg::*;
#(
	parameter int STORE_WORDS = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // word_index[11:0], word_data[75:12], virt_addr[123:76]
	input  logic         s_tuser,  // action
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [55:0]  m_tdata,  // status[1:0], phys_result[53:2]
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	localparam int AW = $clog2(STORE_WORDS);

	ptw_item_t          item;
	ptw_res_t           res;
	logic               res_valid;
	logic               res_ready;
	logic [PA_W-1:0]    root_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic               m_tvalid_q;
	ptw_res_t           out_q;

	// unpack the input transaction
	assign item.action     = s_tuser;
	assign item.word_index = s_tdata[11:0];
	assign item.word_data  = s_tdata[75:12];
	assign item.virt_addr  = s_tdata[123:76];

	ptw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.root_addr (root_addr)
	);

	ptw_store #(
		.STORE_WORDS (STORE_WORDS),
		.AW          (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ptw_seq #(
		.STORE_WORDS (STORE_WORDS),
		.AW          (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.root_addr (root_addr),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// output register
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_q.phys_result, out_q.status};

endmodule
